// File: rtl/core/bmsp_pkg.sv
// Package: widths, action codes, register indexes and reset constants.
package bmsp_pkg;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned REG_IDX_W  = 1;

  localparam int unsigned MEM_BYTES_DEF   = 65536;
  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  // register reset values
  localparam logic [ADDR_W-1:0] IO_BASE_RST   = 16'hfff0;
  localparam logic [ADDR_W-1:0] RAM_LIMIT_RST = 16'hffef;

  // memory preload: zero below the I/O region, all ones from it up
  localparam logic [ADDR_W-1:0] IO_FILL_START = 16'hfff0;
  localparam logic [DATA_W-1:0] FILL_BYTE     = 8'hff;

  typedef enum logic [ACTION_W-1:0] {
    ACT_BUS_READ  = 2'd0,
    ACT_BUS_WRITE = 2'd1,
    ACT_HOST_PUSH = 2'd2,
    ACT_HOST_PULL = 2'd3
  } action_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IO_BASE   = 1'b0,
    REG_RAM_LIMIT = 1'b1
  } reg_idx_e;

endpackage

// File: rtl/core/bus_memory_with_serial_port.sv
// Top level: byte-wide bus target with memory and a two-queue serial port.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-----------------------------------------
//  item in   | start_i & ~busy_o        | action_i, address_i, write_data_i
//  result    | valid_o (one-cycle pulse)| read_data_o, done_res_o
//  config    | psel & penable & pwrite  | paddr, pwdata (prdata on read)
//            | & pready (always high)   |
//
// One item per cycle while busy_o is low; its result appears on the cycle after the accepting edge,
// from memory, queue or status registers read at that edge.
// After reset busy_o stays high while a clearing pass loads the memory with its
// preload (0x00, 0xFF from 0xFFF0 up). Config writes still go in.
// The receiver cannot stall: each result shows for exactly one cycle.
module bus_memory_with_serial_port #(
  parameter int unsigned MEM_BYTES   = bmsp_pkg::MEM_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH = bmsp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [bmsp_pkg::ACTION_W-1:0] action_i,
  input  logic [bmsp_pkg::ADDR_W-1:0]   address_i,
  input  logic [bmsp_pkg::DATA_W-1:0]   write_data_i,
  // result channel
  output logic                          valid_o,
  output logic [bmsp_pkg::DATA_W-1:0]   read_data_o,
  output logic                          done_res_o,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmsp_pkg::PADDR_W-1:0]  paddr,
  input  logic [bmsp_pkg::PDATA_W-1:0]  pwdata,
  output logic [bmsp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import bmsp_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam bit MEM_POW2    = (MEM_BYTES & (MEM_BYTES - 1)) == 0;

  // result source, picked at accept and resolved after the read registers
  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_STAT,
    SEL_MEM,
    SEL_RXQ,
    SEL_TXQ
  } rsel_e;

  // ---------------------------------------------------------------- config
  logic [ADDR_W-1:0] io_base_q, ram_limit_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      io_base_q   <= IO_BASE_RST;
      ram_limit_q <= RAM_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IO_BASE:   io_base_q   <= pwdata[ADDR_W-1:0];
        REG_RAM_LIMIT: ram_limit_q <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IO_BASE:   prdata = PDATA_W'(io_base_q);
      REG_RAM_LIMIT: prdata = PDATA_W'(ram_limit_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- clearing pass
  logic          clr_act_q;
  logic [AW-1:0] clr_idx_q;
  logic [DATA_W-1:0] clr_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_act_q <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_act_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == AW'(MEM_BYTES - 1)) clr_act_q <= 1'b0;
    end
  end

  assign clr_byte = (32'(clr_idx_q) >= 32'(IO_FILL_START)) ? FILL_BYTE : '0;
  assign busy_o   = clr_act_q;

  // ------------------------------------------------------- address decode
  logic          acc;
  logic [ADDR_W-1:0] data_addr;
  logic          is_stat, is_data, in_ram;
  logic [AW-1:0] mem_idx;

  assign acc       = start_i & ~busy_o;
  assign data_addr = io_base_q + 1'b1;
  assign is_stat   = address_i == io_base_q;
  assign is_data   = address_i == data_addr;
  assign in_ram    = address_i <= ram_limit_q;

  // address wraps modulo the memory size
  if (MEM_POW2) begin : g_idx_mask
    assign mem_idx = address_i[AW-1:0];
  end else begin : g_idx_recip
    // exact quotient for 16-bit addresses: ceil(2^32 / MEM_BYTES), shift by 32
    localparam logic [63:0] RECIP_FULL = ((64'd1 << 32) + 64'(MEM_BYTES) - 64'd1)
                                         / 64'(MEM_BYTES);
    localparam logic [24:0] RECIP = RECIP_FULL[24:0];
    logic [40:0] prod;
    logic [7:0]  quo;
    logic [23:0] qm;
    logic [ADDR_W-1:0] rem;
    assign prod    = 41'(address_i) * 41'(RECIP);
    assign quo     = prod[39:32];
    assign qm      = 24'(quo) * 24'(MEM_BYTES);
    assign rem     = address_i - qm[ADDR_W-1:0];
    assign mem_idx = rem[AW-1:0];
  end

  // ------------------------------------------------------------- queues
  logic [PW-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
  logic [CW-1:0] rx_cnt_q, tx_cnt_q;
  logic          rx_empty, rx_full, tx_empty, tx_full;

  assign rx_empty = rx_cnt_q == '0;
  assign rx_full  = rx_cnt_q == CW'(QUEUE_DEPTH);
  assign tx_empty = tx_cnt_q == '0;
  assign tx_full  = tx_cnt_q == CW'(QUEUE_DEPTH);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // --------------------------------------------------------- item decode
  logic  rx_push, rx_pop, tx_push, tx_pop, mem_wr, done_d;
  rsel_e sel_d;

  always_comb begin
    rx_push = 1'b0;
    rx_pop  = 1'b0;
    tx_push = 1'b0;
    tx_pop  = 1'b0;
    mem_wr  = 1'b0;
    sel_d   = SEL_ZERO;
    case (action_i)
      ACT_BUS_READ: begin
        if (is_stat) begin
          sel_d = SEL_STAT;
        end else if (is_data) begin
          // empty receive queue reads zero, nothing popped
          rx_pop = ~rx_empty;
          sel_d  = rx_empty ? SEL_ZERO : SEL_RXQ;
        end else begin
          sel_d = SEL_MEM;
        end
      end
      ACT_BUS_WRITE: begin
        if (is_data) tx_push = ~tx_full;  // full queue drops the byte
        else         mem_wr  = in_ram;    // status address stores like any other
      end
      ACT_HOST_PUSH: begin
        rx_push = ~rx_full;
      end
      ACT_HOST_PULL: begin
        tx_pop = ~tx_empty;
        sel_d  = tx_empty ? SEL_ZERO : SEL_TXQ;
      end
      default: ;
    endcase
    done_d = rx_push | rx_pop | tx_push | tx_pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0;
      rx_tail_q <= '0;
      rx_cnt_q  <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      tx_cnt_q  <= '0;
    end else if (acc) begin
      if (rx_push) begin
        rx_tail_q <= ptr_inc(rx_tail_q);
        rx_cnt_q  <= rx_cnt_q + 1'b1;
      end
      if (rx_pop) begin
        rx_head_q <= ptr_inc(rx_head_q);
        rx_cnt_q  <= rx_cnt_q - 1'b1;
      end
      if (tx_push) begin
        tx_tail_q <= ptr_inc(tx_tail_q);
        tx_cnt_q  <= tx_cnt_q + 1'b1;
      end
      if (tx_pop) begin
        tx_head_q <= ptr_inc(tx_head_q);
        tx_cnt_q  <= tx_cnt_q - 1'b1;
      end
    end
  end

  // ------------------------------------------------------------ memories
  logic [DATA_W-1:0] mem [MEM_BYTES];
  logic [DATA_W-1:0] rxq_mem [QUEUE_DEPTH];
  logic [DATA_W-1:0] txq_mem [QUEUE_DEPTH];
  logic [DATA_W-1:0] mem_rd_q, rxq_rd_q, txq_rd_q;

  always_ff @(posedge clk_i) begin
    if (clr_act_q) begin
      mem[clr_idx_q] <= clr_byte;
    end else if (acc && mem_wr) begin
      mem[mem_idx] <= write_data_i;
    end
    mem_rd_q <= mem[mem_idx];
  end

  always_ff @(posedge clk_i) begin
    if (acc && rx_push) rxq_mem[rx_tail_q] <= write_data_i;
    rxq_rd_q <= rxq_mem[rx_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (acc && tx_push) txq_mem[tx_tail_q] <= write_data_i;
    txq_rd_q <= txq_mem[tx_head_q];
  end

  // -------------------------------------------------------------- result
  logic        valid_q, done_res_q;
  rsel_e       sel_q;
  logic [1:0]  stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      done_res_q <= 1'b0;
      sel_q      <= SEL_ZERO;
    end else begin
      valid_q <= acc;
      if (acc) begin
        done_res_q <= done_d;
        sel_q      <= sel_d;
      end
    end
  end

  // status: bit0 receive not empty, bit1 transmit not full
  always_ff @(posedge clk_i) begin
    if (acc) stat_q <= {~tx_full, ~rx_empty};
  end

  always_comb begin
    case (sel_q)
      SEL_STAT: read_data_o = DATA_W'(stat_q);
      SEL_MEM:  read_data_o = mem_rd_q;
      SEL_RXQ:  read_data_o = rxq_rd_q;
      SEL_TXQ:  read_data_o = txq_rd_q;
      default:  read_data_o = '0;
    endcase
  end

  assign valid_o    = valid_q;
  assign done_res_o = done_res_q;

endmodule

// File: test/tb_top.sv
// Testbench for bus_memory_with_serial_port: directed table, then predictor-checked traffic.
module tb_top;
  import bmsp_pkg::*;

  localparam int unsigned MEM_SIZE    = MEM_BYTES_DEF;
  localparam int unsigned FIFO_DEPTH  = QUEUE_DEPTH_DEF;
  // clearing pass plus ~1100 items with random sender gaps, APB traffic, many times over
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DIR_N       = 25;

  typedef enum logic [1:0] {
    MIX_TRAFFIC,
    FILL_QUEUES,
    DRAIN_QUEUES
  } traffic_e;

  // one directed item; typed = expected result written in the row
  typedef struct packed {
    action_e     act;
    logic [15:0] addr;
    logic [7:0]  wd;
    logic        typed;
    logic [7:0]  rd;
    logic        done;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       done;
  } bus_result_t;

  // ---------------------------------------------------------------- DUT I/O
  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  start_i      = 1'b0;
  logic                  busy_o;
  logic [ACTION_W-1:0]   action_i     = '0;
  logic [ADDR_W-1:0]     address_i    = '0;
  logic [DATA_W-1:0]     write_data_i = '0;
  logic                  valid_o;
  logic [DATA_W-1:0]     read_data_o;
  logic                  done_res_o;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [PADDR_W-1:0]    paddr        = '0;
  logic [PDATA_W-1:0]    pwdata       = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  // typed expectation travels with the item so the monitor sees it at the accepting edge
  logic                  row_typed = 1'b0;
  logic [7:0]            row_rd    = '0;
  logic                  row_done  = 1'b0;

  bus_memory_with_serial_port i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .action_i     (action_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .valid_o      (valid_o),
    .read_data_o  (read_data_o),
    .done_res_o   (done_res_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor state
  logic [7:0]  mem_img [MEM_SIZE];
  logic [7:0]  rx_fifo [FIFO_DEPTH];
  logic [7:0]  tx_fifo [FIFO_DEPTH];
  int unsigned rx_cnt, rx_head, tx_cnt, tx_head;
  logic [15:0] cfg_io_base   = IO_BASE_RST;
  logic [15:0] cfg_ram_limit = RAM_LIMIT_RST;
  logic [15:0] win_lo        = '0;  // small address window so reads hit written bytes

  bus_result_t bytes_due [$];

  int unsigned err_cnt, n_items, n_results, n_moved, n_refused, n_empty;
  int unsigned cycle_cnt;

  // Serve one bus/host event against the shadow state; returns what the block should answer.
  function automatic void model_event(input action_e act, input logic [15:0] addr,
                                      input logic [7:0] wd, output logic [7:0] rd,
                                      output logic done);
    logic [15:0] data_addr;
    data_addr = cfg_io_base + 16'd1;  // wraps at 0xFFFF
    rd   = '0;
    done = 1'b0;
    case (act)
      ACT_BUS_READ: begin
        if (addr == cfg_io_base) begin
          rd = {6'b0, tx_cnt < FIFO_DEPTH, rx_cnt != 0};
        end else if (addr == data_addr) begin
          if (rx_cnt != 0) begin
            rd      = rx_fifo[rx_head];
            rx_head = (rx_head + 1) % FIFO_DEPTH;
            rx_cnt--;
            done    = 1'b1;
          end else begin
            n_empty++;
          end
        end else begin
          rd = mem_img[addr % MEM_SIZE];
        end
      end
      ACT_BUS_WRITE: begin
        // the data address wins over the ram limit; the status address does not
        if (addr == data_addr) begin
          if (tx_cnt < FIFO_DEPTH) begin
            tx_fifo[(tx_head + tx_cnt) % FIFO_DEPTH] = wd;
            tx_cnt++;
            done = 1'b1;
          end else begin
            n_refused++;
          end
        end else if (addr <= cfg_ram_limit) begin
          mem_img[addr % MEM_SIZE] = wd;
        end
      end
      ACT_HOST_PUSH: begin
        if (rx_cnt < FIFO_DEPTH) begin
          rx_fifo[(rx_head + rx_cnt) % FIFO_DEPTH] = wd;
          rx_cnt++;
          done = 1'b1;
        end else begin
          n_refused++;
        end
      end
      default: begin
        if (tx_cnt != 0) begin
          rd      = tx_fifo[tx_head];
          tx_head = (tx_head + 1) % FIFO_DEPTH;
          tx_cnt--;
          done    = 1'b1;
        end else begin
          n_empty++;
        end
      end
    endcase
    if (done) n_moved++;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d, cycle %0d)",
             what, got, want, n_results, cycle_cnt);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------- monitor
  // Compare first (the result belongs to an earlier accepted item, queued in order), then
  // predict the item accepted at this edge.
  always @(posedge clk_i) begin : result_check
    bus_result_t want;
    logic [7:0]  prd;
    logic        pdone;
    if (rst_ni) begin
      if (valid_o) begin
        n_results++;
        if (bytes_due.size() == 0) begin
          report_mismatch("result with no item pending", read_data_o, 0);
        end else begin
          want = bytes_due.pop_front();
          if (read_data_o !== want.rd) report_mismatch("read_data", read_data_o, want.rd);
          if (done_res_o !== want.done) report_mismatch("done_res", done_res_o, want.done);
        end
      end
      if (start_i && !busy_o) begin
        model_event(action_e'(action_i), address_i, write_data_i, prd, pdone);
        if (row_typed) begin
          prd   = row_rd;
          pdone = row_done;
        end
        bytes_due.push_back(bus_result_t'{rd: prd, done: pdone});
        n_items++;
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends up here.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt,
               bytes_due.size());
      $display("FAIL bus_memory_with_serial_port");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  // Present one item and hold it until the edge that accepts it. start_i stays
  // high on return so back-to-back items need no extra assignment.
  task automatic send_item(input action_e act, input logic [15:0] addr, input logic [7:0] wd,
                           input logic typed, input logic [7:0] trd, input logic tdone);
    start_i      <= 1'b1;
    action_i     <= act;
    address_i    <= addr;
    write_data_i <= wd;
    row_typed    <= typed;
    row_rd       <= trd;
    row_done     <= tdone;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Random sender gap; payload wiggles meanwhile to prove start_i gates it.
  task automatic sender_gap(input int unsigned pct);
    if ($urandom_range(0, 99) < pct) begin
      start_i      <= 1'b0;
      action_i     <= ACTION_W'($urandom);
      address_i    <= ADDR_W'($urandom);
      write_data_i <= DATA_W'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every answer is in; there is one result per item.
  task automatic settle();
    start_i <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Setup + access on the config port; ends with psel dropped after the access so the
  // next transfer starts in a fresh time step.
  task automatic apb_access(input logic wr, input reg_idx_e idx, input logic [15:0] wval,
                            output logic [31:0] rval);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, wval};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rval = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_set(input reg_idx_e idx, input logic [15:0] val);
    logic [31:0] got;
    apb_access(1'b1, idx, val, got);
    if (idx == REG_IO_BASE) cfg_io_base = val;
    else                    cfg_ram_limit = val;
    apb_access(1'b0, idx, '0, got);
    if (got[15:0] !== val) report_mismatch("register readback", got[15:0], val);
  endtask

  // ---------------------------------------------------------------- random traffic
  function automatic logic [15:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return cfg_io_base;
    if (r < 40) return cfg_io_base + 16'd1;
    if (r < 45) return cfg_io_base + 16'($urandom_range(0, 1) ? 2 : -1);
    if (r < 58) return cfg_ram_limit + 16'($urandom_range(0, 2)) - 16'd1;
    if (r < 85) return win_lo + 16'($urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  // FILL pushes both queues toward full, DRAIN empties them, MIX is anything.
  task automatic gen_item(input traffic_e mode, output action_e act, output logic [15:0] addr,
                          output logic [7:0] wd);
    int unsigned r;
    r    = $urandom_range(0, 99);
    wd   = 8'($urandom);
    addr = 16'($urandom);  // don't-care for host events, still random
    act  = action_e'($urandom_range(0, 3));
    if (mode != MIX_TRAFFIC && r < 90) begin
      if (r < 10) begin
        act  = ACT_BUS_READ;
        addr = cfg_io_base;
      end else if (r < 50) begin
        act = (mode == FILL_QUEUES) ? ACT_HOST_PUSH : ACT_HOST_PULL;
      end else begin
        act  = (mode == FILL_QUEUES) ? ACT_BUS_WRITE : ACT_BUS_READ;
        addr = cfg_io_base + 16'd1;
      end
    end else if (act == ACT_BUS_READ || act == ACT_BUS_WRITE) begin
      addr = pick_addr();
    end
  endtask

  task automatic run_phase(input logic [15:0] io, input logic [15:0] lim,
                           input int unsigned count, input bit quiet);
    action_e     act;
    logic [15:0] addr;
    logic [7:0]  wd;
    traffic_e    mode;
    int unsigned gap_pct;
    cfg_set(REG_IO_BASE, io);
    cfg_set(REG_RAM_LIMIT, lim);
    win_lo  = $urandom_range(0, 1) ? 16'h0000 : cfg_ram_limit - 16'd7;
    mode    = MIX_TRAFFIC;
    gap_pct = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 24 == 0) mode = traffic_e'($urandom_range(0, 2));
      // stretches of dense traffic alternate with gappy ones
      if (i % 40 == 0) gap_pct = quiet ? 0 : $urandom_range(0, 2) * 30;
      gen_item(mode, act, addr, wd);
      send_item(act, addr, wd, 1'b0, '0, 1'b0);
      sender_gap(gap_pct);
    end
    settle();
  endtask

  // ---------------------------------------------------------------- directed table
  // Reset configuration: status at 0xFFF0, data at 0xFFF1, writes stop at 0xFFEF.
  // Rows with typed = 0 are left to the predictor.
  stim_row_t directed_rows [DIR_N] = '{
    '{ACT_BUS_READ,  16'h0000, 8'h00, 1'b1, 8'h00, 1'b0},  // preload low
    '{ACT_BUS_READ,  16'hffff, 8'h00, 1'b1, 8'hff, 1'b0},  // preload in I/O region
    '{ACT_BUS_READ,  16'hffef, 8'h00, 1'b1, 8'h00, 1'b0},  // last writable byte
    '{ACT_BUS_READ,  16'hfff0, 8'h00, 1'b1, 8'h02, 1'b0},  // status: rx empty, tx room
    '{ACT_BUS_READ,  16'hfff1, 8'h00, 1'b1, 8'h00, 1'b0},  // data read, rx empty
    '{ACT_HOST_PULL, 16'h0000, 8'h00, 1'b1, 8'h00, 1'b0},  // host pull, tx empty
    '{ACT_BUS_WRITE, 16'hffef, 8'ha5, 1'b1, 8'h00, 1'b0},
    '{ACT_BUS_READ,  16'hffef, 8'h00, 1'b1, 8'ha5, 1'b0},
    '{ACT_BUS_WRITE, 16'hfff5, 8'h5a, 1'b1, 8'h00, 1'b0},  // above limit: dropped
    '{ACT_BUS_READ,  16'hfff5, 8'h00, 1'b1, 8'hff, 1'b0},
    '{ACT_BUS_WRITE, 16'hfff0, 8'h3c, 1'b1, 8'h00, 1'b0},  // status address, above limit
    '{ACT_BUS_READ,  16'hfff0, 8'h00, 1'b1, 8'h02, 1'b0},
    '{ACT_BUS_WRITE, 16'h0000, 8'hff, 1'b1, 8'h00, 1'b0},
    '{ACT_BUS_READ,  16'h0000, 8'h00, 1'b1, 8'hff, 1'b0},
    '{ACT_BUS_WRITE, 16'hfff1, 8'h11, 1'b1, 8'h00, 1'b1},  // tx push
    '{ACT_HOST_PUSH, 16'h0000, 8'h80, 1'b1, 8'h00, 1'b1},  // rx push
    '{ACT_BUS_READ,  16'hfff0, 8'h00, 1'b1, 8'h03, 1'b0},  // both bits set
    '{ACT_BUS_READ,  16'hfff1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ACT_HOST_PULL, 16'h0000, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ACT_BUS_WRITE, 16'h8000, 8'h55, 1'b1, 8'h00, 1'b0},
    '{ACT_BUS_READ,  16'h8000, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ACT_HOST_PUSH, 16'h0000, 8'h00, 1'b1, 8'h00, 1'b1},
    '{ACT_HOST_PUSH, 16'h0000, 8'hff, 1'b1, 8'h00, 1'b1},
    '{ACT_BUS_READ,  16'hfff1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ACT_BUS_READ,  16'hfff1, 8'h00, 1'b0, 8'h00, 1'b0}
  };

  // ---------------------------------------------------------------- sequence
  initial begin : main_seq
    logic [31:0] got;
    for (int unsigned a = 0; a < MEM_SIZE; a++) begin
      mem_img[a] = (a >= IO_FILL_START) ? FILL_BYTE : 8'h00;
    end
    rx_cnt  = 0;
    rx_head = 0;
    tx_cnt  = 0;
    tx_head = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register reset values, read while the clearing pass still holds busy_o.
    apb_access(1'b0, REG_IO_BASE, '0, got);
    if (got[15:0] !== IO_BASE_RST) report_mismatch("io_base after reset", got, IO_BASE_RST);
    apb_access(1'b0, REG_RAM_LIMIT, '0, got);
    if (got[15:0] !== RAM_LIMIT_RST)
      report_mismatch("ram_limit after reset", got, RAM_LIMIT_RST);

    // Directed part; the first item waits out the clearing pass.
    for (int unsigned i = 0; i < DIR_N; i++) begin
      send_item(directed_rows[i].act, directed_rows[i].addr, directed_rows[i].wd,
                directed_rows[i].typed, directed_rows[i].rd, directed_rows[i].done);
      sender_gap(25);
    end
    settle();

    // Random phases over several register settings, extremes included.
    run_phase(IO_BASE_RST, RAM_LIMIT_RST, 150, 1'b0);
    run_phase(16'h0000, 16'hffff, 170, 1'b0);  // status at 0, every address but the data address writable
    run_phase(16'hffff, 16'h0000, 170, 1'b0);  // data address wraps to 0
    run_phase(16'h8000, 16'h7fff, 170, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 170, 1'b0);
    run_phase(IO_BASE_RST, RAM_LIMIT_RST, 200, 1'b1);  // closing stretch, no gaps

    repeat (4) @(posedge clk_i);
    $display("Ran %0d items (%0d results): a directed table, then six random phases.",
             n_items, n_results);
    $display("Queue transfers %0d, pushes refused on full %0d, pops on empty %0d.",
             n_moved, n_refused, n_empty);
    if (err_cnt == 0) begin
      $display("PASS bus_memory_with_serial_port");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAIL bus_memory_with_serial_port");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/bmsp_pkg.sv
rtl/core/bus_memory_with_serial_port.sv
test/tb_top.sv
